@@ rtl/amjs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amjs_pkg
// Types, phase codes and constants shared by the modem join sequencer.
// ----------------------------------------------------------------------------
package amjs_pkg;

  localparam int unsigned NUM_INIT_CMDS = 5;

  localparam int unsigned CMD_IDX_W   = 3;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned ERR_CNT_W   = 8;
  localparam int unsigned SEND_CNT_W  = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [TIME_W-1:0]    SYNC_DELAY_MS       = 32'd5000;
  localparam logic [TIME_W-1:0]    REJOIN_GAP_MS       = 32'd1000;
  localparam logic [TIME_W-1:0]    DEFAULT_INTERVAL_MS = 32'd30000;
  localparam logic [ERR_CNT_W-1:0] INIT_TRIES          = 8'd3;

  localparam logic [ERR_CNT_W-1:0] RETRY_LIMIT_RST   = 8'd3;
  localparam logic [TIME_W-1:0]    SEND_INTERVAL_RST = 32'd300000;

  // command codes
  localparam logic [CODE_W-1:0] CODE_NONE    = 4'd0;
  localparam logic [CODE_W-1:0] CODE_JOIN    = 4'd5;
  localparam logic [CODE_W-1:0] CODE_TIMEREQ = 4'd6;
  localparam logic [CODE_W-1:0] CODE_LTIME   = 4'd7;
  localparam logic [CODE_W-1:0] CODE_SEND    = 4'd8;

  // send response classes
  localparam logic [1:0] SRES_OTHER   = 2'd0;
  localparam logic [1:0] SRES_OK      = 2'd1;
  localparam logic [1:0] SRES_TIMEOUT = 2'd2;
  localparam logic [1:0] SRES_ERROR   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 1'b1;

  // bit position of each phase is its external phase code
  typedef enum logic [15:0] {
    PH_INIT             = 16'h0001,
    PH_SEND_CMD         = 16'h0002,
    PH_WAIT_OK          = 16'h0004,
    PH_SEND_JOIN        = 16'h0008,
    PH_WAIT_JOIN_OK     = 16'h0010,
    PH_SEND_TIMEREQ     = 16'h0020,
    PH_WAIT_TIMEREQ_OK  = 16'h0040,
    PH_WAIT_TIME_SYNC   = 16'h0080,
    PH_SEND_LTIME       = 16'h0100,
    PH_WAIT_LTIME       = 16'h0200,
    PH_SEND_PERIODIC    = 16'h0400,
    PH_WAIT_SEND_RSP    = 16'h0800,
    PH_WAIT_INTERVAL    = 16'h1000,
    PH_JOIN_RETRY       = 16'h2000,
    PH_DONE             = 16'h4000,
    PH_ERROR            = 16'h8000
  } phase_t;

  localparam logic [3:0] PHASE_CODE_ERROR = 4'd15;

  typedef struct packed {
    phase_t                  phase;
    logic [CMD_IDX_W-1:0]    init_idx;
    logic [ERR_CNT_W-1:0]    err_cnt;
    logic [SEND_CNT_W-1:0]   send_total;
    logic [TIME_W-1:0]       last_send_ms;
    logic [TIME_W-1:0]       retry_mark_ms;
  } seq_state_t;

  typedef struct packed {
    logic [ERR_CNT_W-1:0] retry_limit;
    logic [TIME_W-1:0]    send_gap_ms;
  } seq_cfg_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] now_ms;
    logic              rsp_ok;
    logic              rsp_join_ok;
    logic              rsp_error;
    logic              rsp_is_time;
    logic [1:0]        send_result;
  } poll_item_t;

  typedef struct packed {
    logic                  cmd_valid;
    logic [CODE_W-1:0]     cmd_code;
    logic [3:0]            phase_code;
    logic [SEND_CNT_W-1:0] sends_done;
    logic                  failed;
  } step_result_t;

  function automatic logic [3:0] phase_code(input phase_t ph);
    logic [3:0] code;
    unique case (ph)
      PH_INIT:            code = 4'd0;
      PH_SEND_CMD:        code = 4'd1;
      PH_WAIT_OK:         code = 4'd2;
      PH_SEND_JOIN:       code = 4'd3;
      PH_WAIT_JOIN_OK:    code = 4'd4;
      PH_SEND_TIMEREQ:    code = 4'd5;
      PH_WAIT_TIMEREQ_OK: code = 4'd6;
      PH_WAIT_TIME_SYNC:  code = 4'd7;
      PH_SEND_LTIME:      code = 4'd8;
      PH_WAIT_LTIME:      code = 4'd9;
      PH_SEND_PERIODIC:   code = 4'd10;
      PH_WAIT_SEND_RSP:   code = 4'd11;
      PH_WAIT_INTERVAL:   code = 4'd12;
      PH_JOIN_RETRY:      code = 4'd13;
      PH_DONE:            code = 4'd14;
      PH_ERROR:           code = PHASE_CODE_ERROR;
      default:            code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/amjs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amjs_step
// Next-state and result logic for one poll step of the join sequencer.
// ----------------------------------------------------------------------------
module amjs_step
  import amjs_pkg::*;
(
  input  seq_state_t   cur,
  input  seq_cfg_t     cfg,
  input  poll_item_t   item,
  output seq_state_t   nxt,
  output step_result_t res
);

  logic                  r_ok, r_join, r_err, r_time;
  logic [1:0]            s_res;
  logic [ERR_CNT_W-1:0]  ec_inc;
  logic [CMD_IDX_W-1:0]  idx_inc;
  logic [TIME_W-1:0]     ref_ms, elapsed, interval;
  logic                  issue;
  logic [CODE_W-1:0]     code;

  // response flags only count when a line arrived
  assign r_ok   = item.kind & item.rsp_ok;
  assign r_join = item.kind & item.rsp_join_ok;
  assign r_err  = item.kind & item.rsp_error;
  assign r_time = item.kind & item.rsp_is_time;
  assign s_res  = item.kind ? item.send_result : SRES_OTHER;

  assign ec_inc  = (cur.err_cnt != '1) ? cur.err_cnt + 1'b1 : cur.err_cnt;
  assign idx_inc = (cur.init_idx != '1) ? cur.init_idx + 1'b1 : cur.init_idx;

  // one shared elapsed-time subtractor
  assign ref_ms   = (cur.phase == PH_WAIT_INTERVAL) ? cur.last_send_ms : cur.retry_mark_ms;
  assign elapsed  = item.now_ms - ref_ms;
  assign interval = (cfg.send_gap_ms != '0) ? cfg.send_gap_ms
                                            : DEFAULT_INTERVAL_MS;

  always_comb begin
    nxt   = cur;
    issue = 1'b0;
    code  = CODE_NONE;
    unique case (cur.phase)
      PH_INIT: begin
        nxt.init_idx      = '0;
        nxt.err_cnt       = '0;
        nxt.retry_mark_ms = '0;
        nxt.phase         = PH_SEND_CMD;
      end
      PH_SEND_CMD: begin
        if (cur.init_idx < CMD_IDX_W'(NUM_INIT_CMDS)) begin
          issue     = 1'b1;
          code      = CODE_W'(cur.init_idx);
          nxt.phase = PH_WAIT_OK;
        end else begin
          nxt.phase = PH_SEND_JOIN;
        end
      end
      PH_WAIT_OK: begin
        if (r_ok) begin
          nxt.init_idx = idx_inc;
          nxt.phase    = PH_SEND_CMD;
        end else if (r_err) begin
          // third counted failure skips the command; a success does not clear the count
          if (ec_inc >= INIT_TRIES) begin
            nxt.init_idx = idx_inc;
            nxt.err_cnt  = '0;
          end else begin
            nxt.err_cnt = ec_inc;
          end
          nxt.phase = PH_SEND_CMD;
        end
      end
      PH_SEND_JOIN: begin
        issue     = 1'b1;
        code      = CODE_JOIN;
        nxt.phase = PH_WAIT_JOIN_OK;
      end
      PH_WAIT_JOIN_OK: begin
        if (r_join) begin
          nxt.phase         = PH_SEND_TIMEREQ;
          nxt.send_total    = '0;
          nxt.err_cnt       = '0;
          nxt.retry_mark_ms = '0;
        end
      end
      PH_SEND_TIMEREQ: begin
        issue     = 1'b1;
        code      = CODE_TIMEREQ;
        nxt.phase = PH_WAIT_TIMEREQ_OK;
      end
      PH_WAIT_TIMEREQ_OK: begin
        if (r_ok) begin
          nxt.phase         = PH_WAIT_TIME_SYNC;
          nxt.retry_mark_ms = item.now_ms;
        end
      end
      PH_WAIT_TIME_SYNC: begin
        // a mark of zero means none taken yet
        if (cur.retry_mark_ms == '0) begin
          nxt.retry_mark_ms = item.now_ms;
        end else if (elapsed >= SYNC_DELAY_MS) begin
          nxt.phase         = PH_SEND_LTIME;
          nxt.retry_mark_ms = '0;
        end
      end
      PH_SEND_LTIME: begin
        issue     = 1'b1;
        code      = CODE_LTIME;
        nxt.phase = PH_WAIT_LTIME;
      end
      PH_WAIT_LTIME: begin
        if (r_time) nxt.phase = PH_SEND_PERIODIC;
      end
      PH_SEND_PERIODIC: begin
        issue     = 1'b1;
        code      = CODE_SEND;
        nxt.phase = PH_WAIT_SEND_RSP;
        if (cur.send_total != '1) nxt.send_total = cur.send_total + 1'b1;
      end
      PH_WAIT_SEND_RSP: begin
        if (s_res == SRES_OK || s_res == SRES_TIMEOUT) begin
          nxt.phase        = PH_WAIT_INTERVAL;
          nxt.err_cnt      = '0;
          nxt.last_send_ms = item.now_ms;
        end else if (s_res == SRES_ERROR) begin
          nxt.err_cnt = ec_inc;
          if (cfg.retry_limit == '0 || ec_inc < cfg.retry_limit) begin
            nxt.phase = PH_JOIN_RETRY;
          end else begin
            nxt.phase = PH_ERROR;
          end
        end
      end
      PH_WAIT_INTERVAL: begin
        if (elapsed >= interval) nxt.phase = PH_SEND_LTIME;
      end
      PH_JOIN_RETRY: begin
        if (cur.retry_mark_ms == '0 || elapsed >= REJOIN_GAP_MS) begin
          nxt.retry_mark_ms = item.now_ms;
          nxt.phase         = PH_SEND_JOIN;
        end
      end
      PH_DONE, PH_ERROR: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign res.cmd_valid  = issue;
  assign res.cmd_code   = code;
  assign res.phase_code = phase_code(nxt.phase);
  assign res.sends_done = nxt.send_total;
  assign res.failed     = (nxt.phase == PH_ERROR);

endmodule

@@ rtl/at_modem_join_sequencer_unit.sv @@
`timescale 1ns / 1ps
// A poll beat's result is registered into the output register on accept.
// Throughput: one beat per cycle unless stalled; state updates with the result.
// Input ready holds high while the output register is empty or being drained.
// Reset (synchronous, active low): phase INIT, counters and time marks cleared,
// retry limit 3, send interval 300000 ms, output register empty.
// ----------------------------------------------------------------------------
// at_modem_join_sequencer_unit
// AT modem bring-up sequencer: one poll beat in, one command/status beat out.
// ----------------------------------------------------------------------------
module at_modem_join_sequencer_unit
  import amjs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  in_rsp_ok,
  input  logic                  in_rsp_join_ok,
  input  logic                  in_rsp_error,
  input  logic                  in_rsp_is_time,
  input  logic [1:0]            in_send_result,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_cmd_valid,
  output logic [CODE_W-1:0]     out_cmd_code,
  output logic [3:0]            out_phase_code,
  output logic [SEND_CNT_W-1:0] out_sends_done,
  output logic                  out_failed
);

  seq_state_t   state_r, state_nxt;
  seq_cfg_t     cfg_r;
  poll_item_t   item;
  step_result_t res_nxt, res_r;
  logic         out_valid_r;
  logic         accept;

  assign item = '{kind:        in_kind,
                  now_ms:      in_now_ms,
                  rsp_ok:      in_rsp_ok,
                  rsp_join_ok: in_rsp_join_ok,
                  rsp_error:   in_rsp_error,
                  rsp_is_time: in_rsp_is_time,
                  send_result: in_send_result};

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  amjs_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (item),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit <= RETRY_LIMIT_RST;
      cfg_r.send_gap_ms <= SEND_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT:   cfg_r.retry_limit <= cfg_wdata[ERR_CNT_W-1:0];
        CFG_SEND_INTERVAL: cfg_r.send_gap_ms <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_INIT;
      state_r.init_idx      <= '0;
      state_r.err_cnt       <= '0;
      state_r.send_total    <= '0;
      state_r.last_send_ms  <= '0;
      state_r.retry_mark_ms <= '0;
      out_valid_r           <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cmd_valid  = res_r.cmd_valid;
  assign out_cmd_code   = res_r.cmd_code;
  assign out_phase_code = res_r.phase_code;
  assign out_sends_done = res_r.sends_done;
  assign out_failed     = res_r.failed;

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.phase))
    else $error("phase register not one-hot");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_ERROR |=> state_r.phase == PH_ERROR)
    else $error("left the error phase");

  a_failed_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_failed == (out_phase_code == PHASE_CODE_ERROR)))
    else $error("failed flag disagrees with phase code");

  a_no_cmd_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_cmd_valid |-> out_cmd_code == CODE_NONE)
    else $error("command code set without a command");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_phase_code == phase_code(state_r.phase)
               && out_sends_done == state_r.send_total)
    else $error("result beat disagrees with stored state");
`endif

endmodule
